// ===== rtl/core/nec_ir_frame_decoder_top_assert.svh =====
// Assertion macros for the NEC IR frame decoder.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef NEC_IR_FRAME_DECODER_TOP_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NIRFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NIRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nirfd_pkg.sv =====
// Shared types and constants for the NEC IR frame decoder.
// No dependencies.
package nirfd_pkg;

    localparam int DUR_W      = 24;   // duration field width
    localparam int UNIT_W     = 20;   // unit_duration register width
    localparam int SIZE_W     = 24;   // unit * 16 fits here
    localparam int FRAME_BITS = 32;
    localparam int UNIT_RESET = 560;

    // recogniser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SSPACE = 2'd1;
    localparam logic [1:0] PH_BMARK  = 2'd2;
    localparam logic [1:0] PH_BSPACE = 2'd3;

    // threshold slots, one per pulse multiple
    localparam logic [1:0] M16 = 2'd0;
    localparam logic [1:0] M8  = 2'd1;
    localparam logic [1:0] M1  = 2'd2;
    localparam logic [1:0] M3  = 2'd3;

    typedef struct packed {
        logic                          busy;
        logic [3:0][SIZE_W:0]          hi;
        logic [3:0][SIZE_W-1:0]        lo;
    } t_thresh;

endpackage

// ===== rtl/core/nirfd_thresh.sv =====
// Holds unit_duration and the match window bounds for each pulse multiple.
// Recomputes the bounds after a write, one multiple per cycle. Depends on nirfd_pkg.
module nirfd_thresh #(
    parameter int TOLERANCE_DIVISOR = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [nirfd_pkg::UNIT_W-1:0] i_cfg_data,
    output logic                        o_cfg_ready,
    output nirfd_pkg::t_thresh          o_thr
);
    import nirfd_pkg::*;

    // size / TOLERANCE_DIVISOR as (size * RECIP) >> SH, exact for any size below 2**SIZE_W
    localparam int RL = $clog2(TOLERANCE_DIVISOR);
    localparam int SH = SIZE_W + RL;
    localparam int PW = SH + SIZE_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(TOLERANCE_DIVISOR) - 64'd1) / 64'(TOLERANCE_DIVISOR);

    localparam int S16 = UNIT_RESET * 16;
    localparam int S8  = UNIT_RESET * 8;
    localparam int S1  = UNIT_RESET;
    localparam int S3  = UNIT_RESET * 3;

    logic [UNIT_W-1:0]   r_unit;
    logic                r_busy;
    logic [1:0]          r_sel;
    logic [3:0][SIZE_W:0]   r_hi;
    logic [3:0][SIZE_W-1:0] r_lo;

    logic [SIZE_W-1:0]   w_size;
    logic [PW-1:0]       w_prod;
    logic [SIZE_W-1:0]   w_dev;
    logic                w_wr;

    assign w_wr = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (r_sel)
            M16:     w_size = {r_unit, 4'b0};
            M8:      w_size = {1'b0, r_unit, 3'b0};
            M1:      w_size = SIZE_W'(r_unit);
            M3:      w_size = SIZE_W'(r_unit) + SIZE_W'({r_unit, 1'b0});
            default: w_size = '0;
        endcase
    end

    always_comb begin
        w_prod = PW'(w_size) * PW'(RECIP);
        w_dev  = w_prod[PW-1:SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_W'(UNIT_RESET);
            r_busy <= 1'b0;
            r_sel  <= M16;
            r_lo[M16] <= SIZE_W'(S16 - S16 / TOLERANCE_DIVISOR);
            r_hi[M16] <= (SIZE_W + 1)'(S16 + S16 / TOLERANCE_DIVISOR);
            r_lo[M8]  <= SIZE_W'(S8 - S8 / TOLERANCE_DIVISOR);
            r_hi[M8]  <= (SIZE_W + 1)'(S8 + S8 / TOLERANCE_DIVISOR);
            r_lo[M1]  <= SIZE_W'(S1 - S1 / TOLERANCE_DIVISOR);
            r_hi[M1]  <= (SIZE_W + 1)'(S1 + S1 / TOLERANCE_DIVISOR);
            r_lo[M3]  <= SIZE_W'(S3 - S3 / TOLERANCE_DIVISOR);
            r_hi[M3]  <= (SIZE_W + 1)'(S3 + S3 / TOLERANCE_DIVISOR);
        end else if (w_wr) begin
            r_unit <= i_cfg_data;
            r_busy <= 1'b1;
            r_sel  <= M16;
        end else if (r_busy) begin
            r_lo[r_sel] <= w_size - w_dev;
            r_hi[r_sel] <= {1'b0, w_size} + {1'b0, w_dev};
            r_sel       <= r_sel + 2'd1;
            if (r_sel == M3) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = !r_busy;
    assign o_thr.busy  = r_busy;
    assign o_thr.hi    = r_hi;
    assign o_thr.lo    = r_lo;

endmodule

// ===== rtl/core/nec_ir_frame_decoder_top.sv =====
// NEC IR frame decoder: mark/space durations in, decoded frames out.
// The closing mark passes the input register, then the result register, to the output.
// Throughput: one item per cycle; stalls if a result waits unaccepted or bounds recompute.
// Synchronous active-low reset loads unit_duration 560 and its bounds at once.
// A config write recomputes the bounds, one multiple per cycle, holding off input until done.
// Depends on nirfd_pkg, nirfd_thresh and the assertion macro header.
module nec_ir_frame_decoder_top #(
    parameter int DURATION_BITS     = 24,
    parameter int TOLERANCE_DIVISOR = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [nirfd_pkg::UNIT_W-1:0] i_cfg_data,   // unit_duration
    output logic                         o_cfg_ready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nirfd_pkg::DUR_W-1:0]  s_axis_tdata,  // [23:0] duration
    input  logic [0:0]                   s_axis_tuser,  // [0] is_mark
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata   // [15:0] ir_code, [47:16] raw_code
);
    import nirfd_pkg::*;

    `include "nec_ir_frame_decoder_top_assert.svh"

    localparam int DW = (DURATION_BITS < DUR_W) ? DURATION_BITS : DUR_W;

    t_thresh            w_thr;

    logic               r_in_valid;
    logic               r_in_mark;
    logic [DUR_W-1:0]   r_in_dur;

    logic [1:0]         r_phase, n_phase;
    logic [31:0]        r_shift, n_shift;
    logic [5:0]         r_count, n_count;

    logic               r_out_valid;
    logic [15:0]        r_ir_code;
    logic [31:0]        r_raw_code;

    logic               w_in_xfer;
    logic               w_proc;
    logic               w_emit;
    logic [3:0]         w_hit;
    logic [1:0]         w_restart;

    nirfd_thresh #(
        .TOLERANCE_DIVISOR(TOLERANCE_DIVISOR)
    ) u_thresh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .o_thr      (w_thr)
    );

    // item in the input register moves on when the result slot will be free
    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !w_thr.busy && (!r_in_valid || w_proc);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_hit[k] = (r_in_dur >= w_thr.lo[k]) && ({1'b0, r_in_dur} <= w_thr.hi[k]);
        end
    end

    // a failed item is retried as a start mark
    assign w_restart = (r_in_mark && w_hit[M16]) ? PH_SSPACE : PH_IDLE;

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_count = r_count;
        w_emit  = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                n_phase = w_restart;
            end
            PH_SSPACE: begin
                if (!r_in_mark && w_hit[M8]) begin
                    n_phase = PH_BMARK;
                    n_shift = '0;
                    n_count = '0;
                end else begin
                    n_phase = w_restart;
                end
            end
            PH_BMARK: begin
                if (r_in_mark && w_hit[M1]) begin
                    if (r_count >= 6'(FRAME_BITS)) begin
                        w_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_BSPACE;
                    end
                end else begin
                    n_phase = w_restart;
                end
            end
            PH_BSPACE: begin
                if (!r_in_mark && w_hit[M1]) begin
                    n_shift = {1'b0, r_shift[31:1]};
                    n_count = r_count + 6'd1;
                    n_phase = PH_BMARK;
                end else if (!r_in_mark && w_hit[M3]) begin
                    n_shift = {1'b1, r_shift[31:1]};
                    n_count = r_count + 6'd1;
                    n_phase = PH_BMARK;
                end else begin
                    n_phase = w_restart;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_shift <= n_shift;
                r_count <= n_count;
            end
            if (w_proc && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_mark <= s_axis_tuser[0];
            r_in_dur  <= DUR_W'(s_axis_tdata[DW-1:0]);
        end
        if (w_proc && w_emit) begin
            r_ir_code  <= {r_shift[7:0], r_shift[23:16]};
            r_raw_code <= {r_shift[7:0], ~r_shift[15:8], r_shift[23:16], ~r_shift[31:24]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_raw_code, r_ir_code};

    `NIRFD_ASSERT_NOW(a_busy_blocks_input, w_thr.busy, !s_axis_tready, "input taken during recompute")
    `NIRFD_ASSERT_NOW(a_count_in_space, r_phase == PH_BSPACE, r_count < 6'(FRAME_BITS), "bit count overrun")
    `NIRFD_ASSERT_NEXT(a_cfg_starts_recompute, i_cfg_valid && o_cfg_ready, w_thr.busy, "no recompute after write")
    `NIRFD_ASSERT_NEXT(a_emit_fills_output, w_proc && w_emit, r_out_valid && r_phase == PH_IDLE, "result lost")

endmodule
